>>> src/tbp_pkg.sv
// Shared types, constants and helper functions of the tournament branch predictor.
`default_nettype none
package tbp_pkg;

  // Command codes of an input word
  localparam logic CMD_PREDICT = 1'b0;
  localparam logic CMD_TRAIN   = 1'b1;

  // Counter values after reset
  localparam logic [1:0] CTR_INIT_PRED   = 2'd2;
  localparam logic [1:0] CTR_INIT_CHOOSE = 2'd1;
  localparam logic [1:0] CTR_MAX         = 2'd3;
  localparam logic [1:0] CTR_MIN         = 2'd0;

  typedef struct packed {
    logic        command;
    logic [31:0] pc;
    logic        outcome;
  } req_t;

  typedef struct packed {
    logic prediction;
    logic chose_global;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;        // write reset values at the sweep address
    logic capture;      // latch the incoming word
    logic read_first;   // read history, chooser and gshare tables
    logic read_second;  // read the local counter picked by the history
    logic evaluate;     // form the result and write back on train
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;
  } sts_t;

  // Saturating step of a 2-bit counter toward the given direction
  function automatic logic [1:0] sat_toward(input logic [1:0] c, input logic taken);
    logic [1:0] r;
    if (taken) begin
      r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
    end else begin
      r = (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/tbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> src/tbp_datapath.sv
// Predictor tables, global history, clearing sweep and result register.
`default_nettype none
module tbp_datapath import tbp_pkg::*; #(
  parameter int LOCAL_INDEX_BITS   = 6,
  parameter int LOCAL_HISTORY_BITS = 6,
  parameter int GLOBAL_INDEX_BITS  = 12,
  parameter int CHOOSER_INDEX_BITS = 12
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire req_t request,
  input  wire ctl_t ctl,
  output sts_t      sts,
  output rsp_t      result
);

  localparam int LIB  = LOCAL_INDEX_BITS;
  localparam int LHB  = LOCAL_HISTORY_BITS;
  localparam int GIB  = GLOBAL_INDEX_BITS;
  localparam int CIB  = CHOOSER_INDEX_BITS;
  localparam int LCW  = LIB + LHB;
  localparam int M1   = (LCW > GIB) ? LCW : GIB;
  localparam int CLRW = (M1 > CIB) ? M1 : CIB;

  req_t             req_q;
  logic [GIB-1:0]   ghist;
  logic [CLRW-1:0]  clr_cnt;

  logic [LHB-1:0]   hist_rd;
  logic [1:0]       lc_rd;
  logic [1:0]       gc_rd;
  logic [1:0]       cc_rd;

  logic [LIB-1:0]   li;
  logic [GIB-1:0]   gi;
  logic [CIB-1:0]   ci;
  logic [LCW-1:0]   lslot;

  logic             lpred;
  logic             gpred;
  logic             use_g;
  logic             lok;
  logic             gok;
  logic             wr_train;

  logic             wr_en;
  logic [LIB-1:0]   hist_waddr;
  logic [LHB-1:0]   hist_wdata;
  logic [LCW-1:0]   lc_waddr;
  logic [1:0]       lc_wdata;
  logic [GIB-1:0]   gc_waddr;
  logic [1:0]       gc_wdata;
  logic [CIB-1:0]   cc_waddr;
  logic [1:0]       cc_wdata;
  logic [1:0]       cc_step;

  // Index the tables from the latched word
  assign li    = req_q.pc[LIB-1:0];
  assign gi    = ghist ^ req_q.pc[GIB-1:0];
  assign ci    = req_q.pc[CIB-1:0];
  assign lslot = {li, hist_rd};

  // Decode the counters into predictions
  assign lpred = lc_rd[1];
  assign gpred = gc_rd[1];
  assign use_g = cc_rd[1];
  assign lok   = (lpred == req_q.outcome);
  assign gok   = (gpred == req_q.outcome);

  // Chooser moves only when exactly one predictor was right
  always_comb begin
    if (gok && !lok) begin
      cc_step = sat_toward(cc_rd, 1'b1);
    end else if (lok && !gok) begin
      cc_step = sat_toward(cc_rd, 1'b0);
    end else begin
      cc_step = cc_rd;
    end
  end

  // Select write port sources: sweep during clear, updates on train
  assign wr_train = ctl.evaluate && (req_q.command == CMD_TRAIN);
  assign wr_en    = ctl.clear || wr_train;

  always_comb begin
    if (ctl.clear) begin
      hist_waddr = clr_cnt[LIB-1:0];
      hist_wdata = '0;
      lc_waddr   = clr_cnt[LCW-1:0];
      lc_wdata   = CTR_INIT_PRED;
      gc_waddr   = clr_cnt[GIB-1:0];
      gc_wdata   = CTR_INIT_PRED;
      cc_waddr   = clr_cnt[CIB-1:0];
      cc_wdata   = CTR_INIT_CHOOSE;
    end else begin
      hist_waddr = li;
      hist_wdata = LHB'({hist_rd, req_q.outcome});
      lc_waddr   = lslot;
      lc_wdata   = sat_toward(lc_rd, req_q.outcome);
      gc_waddr   = gi;
      gc_wdata   = sat_toward(gc_rd, req_q.outcome);
      cc_waddr   = ci;
      cc_wdata   = cc_step;
    end
  end

  assign sts.clear_last = &clr_cnt;

  // Sweep counter and global history
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      ghist   <= '0;
    end else begin
      if (ctl.clear) begin
        clr_cnt <= clr_cnt + CLRW'(1);
      end
      if (wr_train) begin
        ghist <= GIB'({ghist, req_q.outcome});
      end
    end
  end

  // Hold the input word and the result
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      req_q <= request;
    end
    if (ctl.evaluate) begin
      result.prediction   <= use_g ? gpred : lpred;
      result.chose_global <= use_g;
    end
  end

  tbp_ram #(.WIDTH(LHB), .DEPTH(2 ** LIB)) u_hist_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (hist_waddr),
    .wr_data (hist_wdata),
    .rd_en   (ctl.read_first),
    .rd_addr (li),
    .rd_data (hist_rd)
  );

  tbp_ram #(.WIDTH(2), .DEPTH(2 ** LCW)) u_local_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (lc_waddr),
    .wr_data (lc_wdata),
    .rd_en   (ctl.read_second),
    .rd_addr (lslot),
    .rd_data (lc_rd)
  );

  tbp_ram #(.WIDTH(2), .DEPTH(2 ** GIB)) u_global_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (gc_waddr),
    .wr_data (gc_wdata),
    .rd_en   (ctl.read_first),
    .rd_addr (gi),
    .rd_data (gc_rd)
  );

  tbp_ram #(.WIDTH(2), .DEPTH(2 ** CIB)) u_chooser_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cc_waddr),
    .wr_data (cc_wdata),
    .rd_en   (ctl.read_first),
    .rd_addr (ci),
    .rd_data (cc_rd)
  );

endmodule
`default_nettype wire

>>> src/tbp_ctrl.sv
// Controller state machine: clearing sweep, two read steps and write-back.
`default_nettype none
module tbp_ctrl import tbp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire sts_t sts,
  output ctl_t      ctl,
  output logic      busy,
  output logic      done
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ1,
    S_READ2,
    S_EVAL
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = start && !busy;

  // Next state
  always_comb begin
    case (state)
      S_CLEAR: state_next = sts.clear_last ? S_IDLE : S_CLEAR;
      S_IDLE:  state_next = accept ? S_READ1 : S_IDLE;
      S_READ1: state_next = S_READ2;
      S_READ2: state_next = S_EVAL;
      S_EVAL:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Decode datapath commands
  always_comb begin
    ctl.clear       = (state == S_CLEAR);
    ctl.capture     = (state == S_IDLE) && accept;
    ctl.read_first  = (state == S_READ1);
    ctl.read_second = (state == S_READ2);
    ctl.evaluate    = (state == S_EVAL);
  end

  // Hold state, busy and the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      busy  <= 1'b1;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
      done  <= (state == S_EVAL);
    end
  end

endmodule
`default_nettype wire

>>> src/tournament_branch_predictor_core.sv
// Top level of the tournament branch predictor: controller, datapath and checks.
//
// After reset the block sweeps its tables to their reset values, one address per
// cycle over 2**max(LOCAL_INDEX_BITS+LOCAL_HISTORY_BITS, GLOBAL_INDEX_BITS,
// CHOOSER_INDEX_BITS) addresses (4096 with the defaults); busy stays high until
// the sweep ends. A word is taken when start is high and busy is low. Its result
// shows on result with result_valid high for one cycle, once the two read steps
// and the write-back step are through, and is taken at the end of that cycle:
// the receiver cannot stall. busy drops in the cycle the result shows, so a new
// word can be taken then, but not before the last one is through. The spacing
// is set by the two dependent reads of registered-read memories (local
// history, then the counter it selects) followed by the write-back step.
`default_nettype none
module tournament_branch_predictor_core import tbp_pkg::*; #(
  parameter int LOCAL_INDEX_BITS   = 6,
  parameter int LOCAL_HISTORY_BITS = 6,
  parameter int GLOBAL_INDEX_BITS  = 12,
  parameter int CHOOSER_INDEX_BITS = 12
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire req_t request,
  output rsp_t      result,
  output logic      result_valid
);

  ctl_t ctl;
  sts_t sts;

  tbp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy),
    .done  (result_valid)
  );

  tbp_datapath #(
    .LOCAL_INDEX_BITS   (LOCAL_INDEX_BITS),
    .LOCAL_HISTORY_BITS (LOCAL_HISTORY_BITS),
    .GLOBAL_INDEX_BITS  (GLOBAL_INDEX_BITS),
    .CHOOSER_INDEX_BITS (CHOOSER_INDEX_BITS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .ctl     (ctl),
    .sts     (sts),
    .result  (result)
  );

  // Every accepted word yields its result
  a_accept_to_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 result_valid)
    else $error("accepted word produced no result");

  // A result strobe is not repeated back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe repeated");

  // The block is ready again when a result shows
  a_ready_on_result: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("busy while result shown");

  // No table writes overlap the clearing sweep and a read step
  a_clear_exclusive: assert property (@(posedge clk) disable iff (rst)
    ctl.clear |-> !(ctl.read_first || ctl.read_second || ctl.evaluate || ctl.capture))
    else $error("clearing sweep overlaps item work");

endmodule
`default_nettype wire
